### hdl/mli_pkg.sv
// Package for the LU matrix inverse: Q15.16 constants, saturating arithmetic
// and the divider request and response types. No dependencies.
package mli_pkg;

	localparam logic signed [31:0] Q_ONE = 32'sd65536;
	localparam logic signed [31:0] Q_MAX = 32'sh7FFFFFFF;
	localparam logic signed [31:0] Q_MIN = 32'sh80000000;

	typedef struct packed {
		logic               start;
		logic signed [31:0] a;
		logic signed [31:0] b;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic               dz;
		logic signed [31:0] q;
	} div_rsp_t;

	function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic signed [32:0] s;
		s = {a[31], a} + {b[31], b};
		if (s[32] != s[31]) qadd = s[32] ? Q_MIN : Q_MAX;
		else qadd = s[31:0];
	endfunction

	function automatic logic signed [31:0] qsub(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic signed [32:0] s;
		s = {a[31], a} - {b[31], b};
		if (s[32] != s[31]) qsub = s[32] ? Q_MIN : Q_MAX;
		else qsub = s[31:0];
	endfunction

	function automatic logic signed [31:0] qneg(input logic signed [31:0] a);
		if (a == Q_MIN) qneg = Q_MAX;
		else qneg = -a;
	endfunction

	// round half up, floor shift by 16, saturate
	function automatic logic signed [31:0] qrnd(input logic signed [63:0] p);
		logic signed [63:0] v;
		v = (p + 64'sd32768) >>> 16;
		if (v > 64'sd2147483647) qrnd = Q_MAX;
		else if (v < -64'sd2147483648) qrnd = Q_MIN;
		else qrnd = v[31:0];
	endfunction

endpackage

### hdl/mli_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module mli_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr_a,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr_b,
	output logic [WIDTH-1:0]                       rd_data_a,
	output logic [WIDTH-1:0]                       rd_data_b
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_addr] <= wr_data;
		rd_data_a <= mem_q[rd_addr_a];
		rd_data_b <= mem_q[rd_addr_b];
	end
endmodule

### hdl/mli_fifo.sv
// Small register FIFO used between front and engine and on the result side.
// No dependencies.
module mli_fifo #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);
	localparam int PW = DEPTH > 1 ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [NW-1:0]    cnt_q;
	logic             do_wr, do_rd;

	assign full    = cnt_q == NW'(DEPTH);
	assign empty   = cnt_q == '0;
	assign rd_data = mem_q[rd_ptr_q];
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_rd) rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_wr && !do_rd) cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr) cnt_q <= cnt_q - 1'b1;
		end
	end
endmodule

### hdl/mli_div.sv
// Radix-2 restoring divider for Q15.16: (a * 2^16) / b, truncated, saturated.
// Depends on mli_pkg.
module mli_div import mli_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);
	logic        run_q;
	logic [5:0]  cnt_q;
	logic [47:0] num_q;
	logic [31:0] den_q;
	logic [31:0] rem_q;
	logic        neg_q;
	logic        done_q;
	logic        dz_q;
	logic signed [31:0] quo_q;
	logic [32:0] rem_sh;
	logic        qbit;
	logic [31:0] rem_nx;
	logic [47:0] quo;
	logic [31:0] abs_a, abs_b;
	logic signed [31:0] qsat;

	assign abs_a  = req.a[31] ? 32'(-req.a) : req.a;
	assign abs_b  = req.b[31] ? 32'(-req.b) : req.b;
	assign rem_sh = {rem_q, num_q[47]};
	assign qbit   = rem_sh >= {1'b0, den_q};
	assign rem_nx = qbit ? 32'(rem_sh - {1'b0, den_q}) : rem_sh[31:0];
	assign quo    = {num_q[46:0], qbit};
	assign rsp    = {done_q, dz_q, quo_q};

	always_comb begin
		if (neg_q) qsat = (quo > 48'h0000_8000_0000) ? Q_MIN : -$signed(quo[31:0]);
		else qsat = (quo > 48'h0000_7FFF_FFFF) ? Q_MAX : $signed(quo[31:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				if (req.b == '0) begin
					done_q <= 1'b1;
				end else begin
					run_q <= 1'b1;
				end
			end else if (run_q && cnt_q == '0) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= {abs_a, 16'h0};
			den_q <= abs_b;
			rem_q <= '0;
			neg_q <= req.a[31] ^ req.b[31];
			cnt_q <= 6'd47;
			dz_q  <= req.b == '0;
			quo_q <= '0;
		end else if (run_q) begin
			num_q <= quo;
			rem_q <= rem_nx;
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) quo_q <= qsat;
		end
	end
endmodule

### hdl/mli_front.sv
// Front end: holds the size register, counts rows and columns of the load
// and tags each item with its store address and an end-of-matrix mark.
module mli_front #(
	parameter int MAX_SIZE = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [3:0]                           cfg_data,
	input  logic                                 push,
	input  logic [31:0]                          element,
	input  logic                                 q_full,
	output logic                                 q_push,
	output logic [32 + $clog2(MAX_SIZE*MAX_SIZE+1):0] q_data,
	output logic [$clog2(MAX_SIZE+1)-1:0]        n
);
	localparam int CW = $clog2(MAX_SIZE + 1);
	localparam int AW = $clog2(MAX_SIZE * MAX_SIZE + 1);

	logic [3:0]    size_q;
	logic [CW-1:0] row_q, col_q;
	logic          end_row, end_mat;
	logic [AW-1:0] addr;

	always_comb begin
		if (size_q == 4'd0) n = CW'(1);
		else if (32'(size_q) > MAX_SIZE) n = CW'(MAX_SIZE);
		else n = CW'(size_q);
	end

	assign end_row = col_q == n - 1'b1;
	assign end_mat = end_row && row_q == n - 1'b1;
	assign addr    = AW'(32'(row_q) * MAX_SIZE + 32'(col_q));
	assign q_push  = push && !q_full;
	assign q_data  = {element, addr, end_mat};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= 4'd8;
			row_q  <= '0;
			col_q  <= '0;
		end else if (cfg_we) begin
			size_q <= cfg_data;
			row_q  <= '0;
			col_q  <= '0;
		end else if (q_push) begin
			if (end_row) begin
				col_q <= '0;
				row_q <= end_mat ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end
endmodule

### hdl/mli_engine.sv
// Back end: loads the factor store, runs elimination, the two triangular
// inversions and the final product with one multiplier and one divider.
// Depends on mli_pkg, mli_ram, mli_div.
module mli_engine import mli_pkg::*; #(
	parameter int MAX_SIZE = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [$clog2(MAX_SIZE+1)-1:0]        n,
	input  logic                                 q_empty,
	input  logic [32 + $clog2(MAX_SIZE*MAX_SIZE+1):0] q_data,
	output logic                                 q_pop,
	input  logic                                 o_full,
	output logic                                 o_push,
	output logic [33:0]                          o_data
);
	localparam int CW    = $clog2(MAX_SIZE + 1);
	localparam int QAW   = $clog2(MAX_SIZE * MAX_SIZE + 1);
	localparam int DEPTH = MAX_SIZE * MAX_SIZE;
	localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;

	typedef enum logic [4:0] {
		S_LOAD, S_PIV_RD, S_PIV, S_DIV_RD, S_DGO, S_DWAIT,
		S_UPD_RD, S_UPD_MUL, S_UPD_RND, S_UPD_WR,
		S_U_ROW, S_UD_RD, S_U_COL, S_L_ROW, S_L_COL, S_O_COL,
		S_T_RD, S_T_MUL, S_T_RND, S_T_ACC, S_FIN
	} state_t;

	typedef enum logic [1:0] {PH_U, PH_L, PH_O} phase_t;
	typedef enum logic [1:0] {DT_ELIM, DT_UD, DT_UJ} dtgt_t;

	state_t  state_q;
	phase_t  phase_q;
	dtgt_t   dt_q;
	logic [CW-1:0] i_q, j_q, k_q, kend;
	logic          sing_q;
	logic signed [31:0] piv_q, acc_q, m_q;
	logic signed [63:0] prod_q;
	logic signed [31:0] opa, opb;

	logic          f_we, v_we;
	logic [AW-1:0] f_wa, v_wa, f_ra, f_rb, v_ra, v_rb;
	logic [31:0]   f_wd, v_wd, f_da, f_db, v_da, v_db;
	div_req_t      dreq;
	div_rsp_t      drsp;

	logic [31:0]   ld_elem;
	logic [QAW-1:0] ld_addr;
	logic          ld_last;

	function automatic logic [AW-1:0] at(input logic [CW-1:0] r, input logic [CW-1:0] c);
		at = AW'(32'(r) * MAX_SIZE + 32'(c));
	endfunction

	assign {ld_elem, ld_addr, ld_last} = q_data;

	mli_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_fstore (
		.clk(clk), .wr_en(f_we), .wr_addr(f_wa), .wr_data(f_wd),
		.rd_addr_a(f_ra), .rd_addr_b(f_rb), .rd_data_a(f_da), .rd_data_b(f_db)
	);

	mli_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_vstore (
		.clk(clk), .wr_en(v_we), .wr_addr(v_wa), .wr_data(v_wd),
		.rd_addr_a(v_ra), .rd_addr_b(v_rb), .rd_data_a(v_da), .rd_data_b(v_db)
	);

	mli_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	assign kend   = (phase_q == PH_O) ? n : j_q;
	assign q_pop  = state_q == S_LOAD && !q_empty;
	assign o_push = state_q == S_FIN && phase_q == PH_O && !o_full;
	assign o_data = {sing_q ? 32'h0 : acc_q, i_q == n - 1'b1 && j_q == n - 1'b1, sing_q};

	// read addresses
	always_comb begin
		f_ra = '0;
		f_rb = '0;
		v_ra = '0;
		v_rb = '0;
		unique case (state_q)
			S_PIV_RD:  f_ra = at(k_q, k_q);
			S_DIV_RD:  f_ra = at(i_q, k_q);
			S_UPD_RD: begin
				f_ra = at(i_q, k_q);
				f_rb = at(k_q, j_q);
			end
			S_UPD_RND: f_ra = at(i_q, j_q);
			S_UD_RD:   f_ra = at(i_q, i_q);
			S_FIN:     f_ra = at(j_q, j_q);
			S_T_RD: begin
				unique case (phase_q)
					PH_U: begin
						v_ra = at(i_q, k_q);
						f_ra = at(k_q, j_q);
					end
					PH_L: begin
						v_ra = at(k_q, i_q);
						f_ra = at(j_q, k_q);
					end
					default: begin
						v_ra = at(i_q, k_q);
						v_rb = at(k_q, j_q);
					end
				endcase
			end
			default: ;
		endcase
	end

	// multiplier operands
	always_comb begin
		if (state_q == S_UPD_MUL) begin
			opa = $signed(f_da);
			opb = $signed(f_db);
		end else begin
			unique case (phase_q)
				PH_U: begin
					opa = $signed(v_da);
					opb = $signed(f_da);
				end
				PH_L: begin
					opa = (k_q == i_q) ? Q_ONE : $signed(v_da);
					opb = $signed(f_da);
				end
				default: begin
					opa = $signed(v_da);
					opb = (k_q == j_q) ? Q_ONE : $signed(v_db);
				end
			endcase
		end
	end

	always_comb begin
		dreq.start = state_q == S_DGO;
		unique case (dt_q)
			DT_ELIM: begin
				dreq.a = $signed(f_da);
				dreq.b = piv_q;
			end
			DT_UD: begin
				dreq.a = Q_ONE;
				dreq.b = $signed(f_da);
			end
			default: begin
				dreq.a = qneg(acc_q);
				dreq.b = $signed(f_da);
			end
		endcase
	end

	// store writes
	always_comb begin
		f_we = 1'b0;
		f_wa = at(i_q, k_q);
		f_wd = drsp.q;
		v_we = 1'b0;
		v_wa = at(i_q, j_q);
		v_wd = drsp.q;
		if (q_pop) begin
			f_we = 1'b1;
			f_wa = AW'(ld_addr);
			f_wd = ld_elem;
		end else if (state_q == S_UPD_WR) begin
			f_we = 1'b1;
			f_wa = at(i_q, j_q);
			f_wd = qsub($signed(f_da), m_q);
		end else if (state_q == S_DWAIT && drsp.done) begin
			f_we = dt_q == DT_ELIM;
			v_we = dt_q != DT_ELIM;
			if (dt_q == DT_UD) v_wa = at(i_q, i_q);
		end else if (state_q == S_FIN && phase_q == PH_L) begin
			v_we = 1'b1;
			v_wa = at(j_q, i_q);
			v_wd = qneg(acc_q);
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= opa * opb;
		m_q    <= qrnd(prod_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			phase_q <= PH_U;
			dt_q    <= DT_ELIM;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			sing_q  <= 1'b0;
			piv_q   <= '0;
			acc_q   <= '0;
		end else begin
			if (state_q == S_DWAIT && drsp.done && drsp.dz) sing_q <= 1'b1;
			unique case (state_q)
				S_LOAD: begin
					if (q_pop && ld_last) begin
						sing_q  <= 1'b0;
						k_q     <= '0;
						state_q <= S_PIV_RD;
					end
				end
				S_PIV_RD: state_q <= S_PIV;
				S_PIV: begin
					piv_q <= $signed(f_da);
					if (f_da == '0) sing_q <= 1'b1;
					if (k_q == n - 1'b1) begin
						phase_q <= PH_U;
						i_q     <= '0;
						state_q <= S_U_ROW;
					end else begin
						i_q     <= k_q + 1'b1;
						state_q <= S_DIV_RD;
					end
				end
				S_DIV_RD: begin
					if (i_q == n) begin
						i_q     <= k_q + 1'b1;
						j_q     <= k_q + 1'b1;
						state_q <= S_UPD_RD;
					end else begin
						dt_q    <= DT_ELIM;
						state_q <= S_DGO;
					end
				end
				S_DGO: state_q <= S_DWAIT;
				S_DWAIT: begin
					if (drsp.done) begin
						unique case (dt_q)
							DT_ELIM: begin
								i_q     <= i_q + 1'b1;
								state_q <= S_DIV_RD;
							end
							DT_UD: begin
								j_q     <= i_q + 1'b1;
								state_q <= S_U_COL;
							end
							default: begin
								j_q     <= j_q + 1'b1;
								state_q <= S_U_COL;
							end
						endcase
					end
				end
				S_UPD_RD:  state_q <= S_UPD_MUL;
				S_UPD_MUL: state_q <= S_UPD_RND;
				S_UPD_RND: state_q <= S_UPD_WR;
				S_UPD_WR: begin
					state_q <= S_UPD_RD;
					if (j_q == n - 1'b1) begin
						j_q <= k_q + 1'b1;
						if (i_q == n - 1'b1) begin
							k_q     <= k_q + 1'b1;
							state_q <= S_PIV_RD;
						end else begin
							i_q <= i_q + 1'b1;
						end
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				S_U_ROW: begin
					if (i_q == n) begin
						i_q     <= '0;
						phase_q <= PH_L;
						state_q <= S_L_ROW;
					end else begin
						dt_q    <= DT_UD;
						state_q <= S_UD_RD;
					end
				end
				S_UD_RD: state_q <= S_DGO;
				S_U_COL: begin
					if (j_q == n) begin
						i_q     <= i_q + 1'b1;
						state_q <= S_U_ROW;
					end else begin
						k_q     <= i_q;
						acc_q   <= '0;
						state_q <= S_T_RD;
					end
				end
				S_L_ROW: begin
					if (i_q == n) begin
						i_q     <= '0;
						j_q     <= '0;
						phase_q <= PH_O;
						state_q <= S_O_COL;
					end else begin
						j_q     <= i_q + 1'b1;
						state_q <= S_L_COL;
					end
				end
				S_L_COL: begin
					if (j_q == n) begin
						i_q     <= i_q + 1'b1;
						state_q <= S_L_ROW;
					end else begin
						k_q     <= i_q;
						acc_q   <= '0;
						state_q <= S_T_RD;
					end
				end
				S_O_COL: begin
					if (j_q == n) begin
						if (i_q == n - 1'b1) begin
							state_q <= S_LOAD;
						end else begin
							i_q <= i_q + 1'b1;
							j_q <= '0;
						end
					end else begin
						k_q     <= (i_q > j_q) ? i_q : j_q;
						acc_q   <= '0;
						state_q <= S_T_RD;
					end
				end
				S_T_RD:  state_q <= S_T_MUL;
				S_T_MUL: state_q <= S_T_RND;
				S_T_RND: state_q <= S_T_ACC;
				S_T_ACC: begin
					acc_q <= qadd(acc_q, m_q);
					if (k_q + 1'b1 == kend) begin
						state_q <= S_FIN;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= S_T_RD;
					end
				end
				S_FIN: begin
					unique case (phase_q)
						PH_U: begin
							dt_q    <= DT_UJ;
							state_q <= S_DGO;
						end
						PH_L: begin
							j_q     <= j_q + 1'b1;
							state_q <= S_L_COL;
						end
						default: begin
							if (!o_full) begin
								j_q     <= j_q + 1'b1;
								state_q <= S_O_COL;
							end
						end
					endcase
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end
endmodule

### hdl/matrix_inverse_lu.sv
// Top level of the LU matrix inverse (Doolittle, no pivoting, Q15.16).
// Depends on mli_pkg, mli_front, mli_fifo, mli_engine.
//
// Input queue: an item is taken when push is high and full is low; items are
// the matrix elements in row-major order, N*N of them.
// Result queue: while empty is low the oldest result sits on element_res,
// last and singular; pop takes it. Results come N*N per matrix, row-major,
// last marking the final one; singular forces all of them to zero.
// matrix_size_we writes the order (0 acts as 1, above MAX_SIZE as MAX_SIZE)
// and restarts the load count; write only while the block is idle.
// Loading takes one item per cycle while the engine waits for a matrix. Once
// the last item is in, the engine runs elimination and the inversions: every
// multiply-accumulate term uses the one shared multiplier and every division
// the one bit-serial divider, N*N divisions and N*N*N terms in all.
// Results enter a two-entry queue as they are computed; a stalled receiver
// holds the engine, and a full four-entry input queue raises full.
// Reset clears the size to 8, the load count, both queues and the flag.
module matrix_inverse_lu #(
	parameter int MAX_SIZE = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        matrix_size_we,
	input  logic [3:0]  matrix_size,
	input  logic        push,
	output logic        full,
	input  logic [31:0] element,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] element_res,
	output logic        last,
	output logic        singular
);
	localparam int CW = $clog2(MAX_SIZE + 1);
	localparam int QW = 33 + $clog2(MAX_SIZE * MAX_SIZE + 1);

	logic          q_push, q_full, q_pop, q_empty, o_push, o_full;
	logic [QW-1:0] q_wdata, q_rdata;
	logic [33:0]   o_wdata, o_rdata;
	logic [CW-1:0] n;

	mli_front #(.MAX_SIZE(MAX_SIZE)) u_front (
		.clk(clk), .arst_n(arst_n), .cfg_we(matrix_size_we), .cfg_data(matrix_size),
		.push(push), .element(element), .q_full(q_full), .q_push(q_push),
		.q_data(q_wdata), .n(n)
	);

	mli_fifo #(.WIDTH(QW), .DEPTH(4)) u_inq (
		.clk(clk), .arst_n(arst_n), .wr_en(q_push), .wr_data(q_wdata), .full(q_full),
		.rd_en(q_pop), .rd_data(q_rdata), .empty(q_empty)
	);

	mli_engine #(.MAX_SIZE(MAX_SIZE)) u_engine (
		.clk(clk), .arst_n(arst_n), .n(n), .q_empty(q_empty), .q_data(q_rdata),
		.q_pop(q_pop), .o_full(o_full), .o_push(o_push), .o_data(o_wdata)
	);

	mli_fifo #(.WIDTH(34), .DEPTH(2)) u_outq (
		.clk(clk), .arst_n(arst_n), .wr_en(o_push), .wr_data(o_wdata), .full(o_full),
		.rd_en(pop), .rd_data(o_rdata), .empty(empty)
	);

	assign full = q_full;
	assign {element_res, last, singular} = o_rdata;
endmodule
